### hw/rtl/lpbcm_pkg.sv
// Shared types, constants and a helper function for the LED panel BCM scan driver.
`default_nettype none

package lpbcm_pkg;

	localparam int BYTE_ADDR_W = 13;
	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W = 7;
	localparam int BYTES_PER_PIXEL = 3;
	localparam int PLANES = 8;

	localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_WIDTH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ACTIVE_HEIGHT = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DISPLAY_BLANK = 2'd2;

	localparam logic [6:0] ACTIVE_WIDTH_RESET = 7'd64;
	localparam logic [6:0] ACTIVE_HEIGHT_RESET = 7'd32;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic operation;
		logic [BYTE_ADDR_W-1:0] byte_address;
		logic [7:0] byte_value;
	} req_t;

	typedef struct packed {
		logic red_top;
		logic green_top;
		logic blue_top;
		logic red_bottom;
		logic green_bottom;
		logic blue_bottom;
		logic [4:0] row_address;
		logic [2:0] plane_index;
		logic last_column;
		logic dark_after_latch;
	} res_t;

	// Bit position of a one-hot plane mask.
	function automatic logic [2:0] plane_pos(input logic [PLANES-1:0] mask);
		logic [2:0] pos;
		pos = 3'd0;
		for (int i = 0; i < PLANES; i++) begin
			if (mask[i]) begin
				pos = pos | 3'(i);
			end
		end
		return pos;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/lpbcm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module lpbcm_ram #(
	parameter int Width = 8,
	parameter int Depth = 64,
	parameter int AddrW = $clog2(Depth)
) (
	input wire logic clk,
	input wire logic wr_en,
	input wire logic [AddrW-1:0] wr_addr,
	input wire logic [Width-1:0] wr_data,
	input wire logic rd_en,
	input wire logic [AddrW-1:0] rd_addr,
	output logic [Width-1:0] rd_data
);

	logic [Width-1:0] mem_q [Depth];
	logic [Width-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### hw/rtl/led_panel_bcm_scan_driver_core.sv
// Top level of the LED panel binary code modulation scan driver.
`default_nettype none

// After reset the block clears its framebuffer, one byte per cycle, over all
// MAX_WIDTH*MAX_HEIGHT*3 bytes (6144 with the default parameters); it takes
// no request during that pass, while register writes are taken at any time.
// A write request passes through the write state, and a tick that does not
// expire the dwell leaves the block idle. An expiring tick forms the row
// pair's base addresses in the top and bottom states with the shared
// multiplier, then reads the six colour bytes of each column one at a time
// through the single framebuffer read port; the output register holds a
// result until it is taken, and a stalled result holds the scan.
module led_panel_bcm_scan_driver_core #(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	output logic req_stall,
	input wire lpbcm_pkg::req_t req,
	output logic res_valid,
	input wire logic res_stall,
	output lpbcm_pkg::res_t res,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [lpbcm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input wire logic [lpbcm_pkg::CFG_DATA_W-1:0] cfg_data
);

	import lpbcm_pkg::*;

	localparam int Depth = MAX_WIDTH * MAX_HEIGHT * BYTES_PER_PIXEL;
	localparam int AddrW = $clog2(Depth);
	localparam int ProdW = 15;
	localparam logic [6:0] MaxW = 7'(MAX_WIDTH);
	localparam logic [6:0] MaxH = 7'(MAX_HEIGHT);
	localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
	localparam logic [AddrW-1:0] PixStep = AddrW'(BYTES_PER_PIXEL);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_WRITE = 6'b000100,
		ST_TOP = 6'b001000,
		ST_BOT = 6'b010000,
		ST_RD = 6'b100000
	} state_t;

	state_t state_q;
	logic [AddrW-1:0] clr_q;
	logic [6:0] active_width_q;
	logic [6:0] active_height_q;
	logic display_blank_q;
	logic [4:0] row_q;
	logic [PLANES-1:0] mask_q;
	logic [7:0] dwell_q;
	logic [BYTE_ADDR_W-1:0] addr_q;
	logic [7:0] value_q;
	logic [AddrW-1:0] top_ptr_q;
	logic [AddrW-1:0] bot_ptr_q;
	logic [5:0] col_q;
	logic [2:0] sub_q;
	logic [4:0] bits_q;
	logic res_valid_q;
	res_t res_q;

	logic [6:0] w_clamp;
	logic [6:0] w_eff;
	logic [6:0] h_eff;
	logic [5:0] half;
	logic [5:0] pairs;
	logic [7:0] stride;
	logic [4:0] row_eff;
	logic [6:0] mul_b;
	logic [ProdW-1:0] prod;
	logic req_acc;
	logic out_free;
	logic col_emit;
	logic last_col;
	logic [5:0] row_inc;
	logic [1:0] rd_ofs;
	logic [AddrW-1:0] rd_addr;
	logic rd_en;
	logic [7:0] rd_data;
	logic cur_bit;
	logic wr_en;
	logic [AddrW-1:0] wr_addr;
	logic [7:0] wr_data;

	assign w_clamp = (active_width_q > MaxW) ? MaxW : active_width_q;
	assign w_eff = (w_clamp == 7'd0) ? 7'd1 : w_clamp;
	assign h_eff = (active_height_q > MaxH) ? MaxH : active_height_q;
	assign half = h_eff[6:1];
	assign pairs = (half == 6'd0) ? 6'd1 : half;
	assign stride = 8'({1'b0, w_eff}) + 8'({w_eff, 1'b0});
	assign row_eff = ({1'b0, row_q} >= pairs) ? 5'd0 : row_q;

	// The one multiplier serves the write range check and both base addresses.
	always_comb begin
		case (state_q)
			ST_WRITE: mul_b = h_eff;
			ST_TOP: mul_b = {2'b00, row_eff};
			ST_BOT: mul_b = {1'b0, half};
			default: mul_b = 7'd0;
		endcase
	end

	assign prod = ProdW'(stride) * ProdW'(mul_b);

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc = req_valid && !req_stall;
	assign out_free = !res_valid_q || !res_stall;
	assign col_emit = (state_q == ST_RD) && (sub_q == 3'd6) && out_free;
	assign last_col = (7'({1'b0, col_q}) + 7'd1 == w_eff);
	assign row_inc = {1'b0, row_q} + 6'd1;
	assign cfg_ready = 1'b1;

	assign rd_ofs = (sub_q < 3'd3) ? sub_q[1:0] : 2'(sub_q - 3'd3);
	assign rd_addr = ((sub_q < 3'd3) ? top_ptr_q : bot_ptr_q) + AddrW'(rd_ofs);
	assign rd_en = (state_q == ST_RD) && (sub_q < 3'd6);
	assign cur_bit = |(rd_data & mask_q);

	always_comb begin
		wr_en = 1'b0;
		wr_addr = clr_q;
		wr_data = 8'd0;
		if (state_q == ST_CLEAR) begin
			wr_en = 1'b1;
		end else if (state_q == ST_WRITE) begin
			wr_en = (ProdW'(addr_q) < prod);
			wr_addr = AddrW'(addr_q);
			wr_data = value_q;
		end
	end

	lpbcm_ram #(
		.Width(8),
		.Depth(Depth)
	) u_store (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en(rd_en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q <= ACTIVE_WIDTH_RESET;
			active_height_q <= ACTIVE_HEIGHT_RESET;
			display_blank_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ACTIVE_WIDTH: active_width_q <= cfg_data;
				CFG_ACTIVE_HEIGHT: active_height_q <= cfg_data;
				CFG_DISPLAY_BLANK: display_blank_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			row_q <= 5'd0;
			mask_q <= 8'd1;
			dwell_q <= 8'd1;
			col_q <= 6'd0;
			sub_q <= 3'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && !res_stall && !col_emit) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AddrW'(1);
					if (clr_q == LastAddr) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_acc) begin
						if (req.operation == OP_WRITE) begin
							state_q <= ST_WRITE;
						end else begin
							dwell_q <= dwell_q - 8'd1;
							if (dwell_q == 8'd1) begin
								state_q <= ST_TOP;
							end
						end
					end
				end
				ST_WRITE: begin
					state_q <= ST_IDLE;
				end
				ST_TOP: begin
					row_q <= row_eff;
					state_q <= ST_BOT;
				end
				ST_BOT: begin
					col_q <= 6'd0;
					sub_q <= 3'd0;
					state_q <= ST_RD;
				end
				ST_RD: begin
					if (sub_q < 3'd6) begin
						sub_q <= sub_q + 3'd1;
					end else if (out_free) begin
						res_valid_q <= 1'b1;
						sub_q <= 3'd0;
						col_q <= col_q + 6'd1;
						if (last_col) begin
							dwell_q <= mask_q;
							state_q <= ST_IDLE;
							if (mask_q[PLANES-1]) begin
								mask_q <= 8'd1;
								row_q <= (row_inc >= pairs) ? 5'd0 : row_inc[4:0];
							end else begin
								mask_q <= {mask_q[PLANES-2:0], 1'b0};
							end
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			addr_q <= req.byte_address;
			value_q <= req.byte_value;
		end
		if (state_q == ST_TOP) begin
			top_ptr_q <= prod[AddrW-1:0];
		end
		if (state_q == ST_BOT) begin
			bot_ptr_q <= top_ptr_q + prod[AddrW-1:0];
		end
		if (state_q == ST_RD) begin
			if (sub_q != 3'd0 && sub_q < 3'd6) begin
				bits_q[sub_q - 3'd1] <= cur_bit;
			end
			if (sub_q == 3'd6 && out_free) begin
				top_ptr_q <= top_ptr_q + PixStep;
				bot_ptr_q <= bot_ptr_q + PixStep;
				res_q.red_top <= bits_q[0];
				res_q.green_top <= bits_q[1];
				res_q.blue_top <= bits_q[2];
				res_q.red_bottom <= bits_q[3];
				res_q.green_bottom <= bits_q[4];
				res_q.blue_bottom <= cur_bit;
				res_q.row_address <= row_q;
				res_q.plane_index <= plane_pos(mask_q);
				res_q.last_column <= last_col;
				res_q.dark_after_latch <= display_blank_q;
			end
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

`ifndef NO_ASSERTIONS
	a_mask_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(mask_q))
		else $error("plane mask is not one-hot");

	a_dwell_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (dwell_q != 8'd0))
		else $error("dwell counter is zero while idle");

	a_expire_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && req.operation == OP_TICK && dwell_q == 8'd1) |=> (state_q == ST_TOP))
		else $error("expired dwell did not start a plane scan");

	a_col_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (7'({1'b0, col_q}) < w_eff && sub_q <= 3'd6))
		else $error("column or read step out of range during scan");
`endif

endmodule

`default_nettype wire

### verif/bcm_scan_checker.sv
// Checker for the LED panel BCM scan driver: predicts the column results and compares them.
module bcm_scan_checker
	import lpbcm_pkg::*;
#(
	parameter int MAX_WIDTH = 64,
	parameter int MAX_HEIGHT = 32
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_stall,
	input req_t req,
	input logic res_valid,
	input logic res_stall,
	input res_t res,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [CFG_INDEX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data,
	output int pending,
	output logic [7:0] dwell_now,
	output int checked,
	output int fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB_BYTES = MAX_WIDTH * MAX_HEIGHT * BYTES_PER_PIXEL;
	localparam int REPORT_LIMIT = 10;

	logic [7:0] frame [FB_BYTES];
	logic [4:0] row_sel;
	logic [7:0] plane_sel;
	logic [7:0] dwell;
	logic [6:0] width_reg;
	logic [6:0] height_reg;
	logic blank_reg;
	res_t column_queue [$];

	initial begin
		checked = 0;
		fail_count = 0;
		pending = 0;
	end

	assign dwell_now = dwell;

	function automatic string describe(input res_t r);
		return $sformatf("rgb top %b%b%b bottom %b%b%b row %0d plane %0d last %b dark %b",
			r.red_top, r.green_top, r.blue_top, r.red_bottom, r.green_bottom,
			r.blue_bottom, r.row_address, r.plane_index, r.last_column, r.dark_after_latch);
	endfunction

	function automatic string field_diffs(input res_t want, input res_t got);
		string s;
		s = "";
		if (want.red_top != got.red_top) s = {s, " red_top"};
		if (want.green_top != got.green_top) s = {s, " green_top"};
		if (want.blue_top != got.blue_top) s = {s, " blue_top"};
		if (want.red_bottom != got.red_bottom) s = {s, " red_bottom"};
		if (want.green_bottom != got.green_bottom) s = {s, " green_bottom"};
		if (want.blue_bottom != got.blue_bottom) s = {s, " blue_bottom"};
		if (want.row_address != got.row_address) s = {s, " row_address"};
		if (want.plane_index != got.plane_index) s = {s, " plane_index"};
		if (want.last_column != got.last_column) s = {s, " last_column"};
		if (want.dark_after_latch != got.dark_after_latch) s = {s, " dark_after_latch"};
		return s;
	endfunction

	task automatic note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT) begin
			$display("%0t: %s", $time, msg);
		end
	endtask

	// Applies one accepted request and queues the columns of a plane shift, if one is due.
	task automatic predict_request(input req_t item);
		int w;
		int h;
		int pairs;
		int top_base;
		int bot_base;
		int pos;
		int c;
		logic [7:0] shown;
		res_t col;
		w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
		if (w == 0) begin
			w = 1;
		end
		h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
		pairs = (h / 2 == 0) ? 1 : h / 2;
		if (item.operation == OP_WRITE) begin
			if (int'(item.byte_address) < w * h * BYTES_PER_PIXEL) begin
				frame[item.byte_address] = item.byte_value;
			end
			return;
		end
		dwell = dwell - 8'd1;
		if (dwell != 8'd0) begin
			return;
		end
		// A row pair left over from a taller panel starts again from the top.
		if (row_sel >= pairs) begin
			row_sel = '0;
		end
		top_base = w * int'(row_sel) * BYTES_PER_PIXEL;
		bot_base = top_base + w * (h / 2) * BYTES_PER_PIXEL;
		shown = plane_sel;
		pos = 0;
		while (pos < 7 && !shown[pos]) begin
			pos++;
		end
		for (c = 0; c < w; c++) begin
			col.red_top = |(frame[top_base + BYTES_PER_PIXEL * c] & shown);
			col.green_top = |(frame[top_base + BYTES_PER_PIXEL * c + 1] & shown);
			col.blue_top = |(frame[top_base + BYTES_PER_PIXEL * c + 2] & shown);
			col.red_bottom = |(frame[bot_base + BYTES_PER_PIXEL * c] & shown);
			col.green_bottom = |(frame[bot_base + BYTES_PER_PIXEL * c + 1] & shown);
			col.blue_bottom = |(frame[bot_base + BYTES_PER_PIXEL * c + 2] & shown);
			col.row_address = row_sel;
			col.plane_index = 3'(pos);
			col.last_column = (c == w - 1);
			col.dark_after_latch = blank_reg;
			column_queue.push_back(col);
		end
		plane_sel = shown << 1;
		if (plane_sel == 8'd0) begin
			plane_sel = 8'd1;
			row_sel = row_sel + 5'd1;
			if (row_sel >= pairs) begin
				row_sel = '0;
			end
		end
		dwell = shown;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_t want;
		string diffs;
		if (!arst_n) begin
			for (int i = 0; i < FB_BYTES; i++) begin
				frame[i] = '0;
			end
			row_sel = '0;
			plane_sel = 8'd1;
			dwell = 8'd1;
			width_reg = ACTIVE_WIDTH_RESET;
			height_reg = ACTIVE_HEIGHT_RESET;
			blank_reg = 1'b0;
			column_queue.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ACTIVE_WIDTH: width_reg = cfg_data;
					CFG_ACTIVE_HEIGHT: height_reg = cfg_data;
					CFG_DISPLAY_BLANK: blank_reg = cfg_data[0];
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (column_queue.size() == 0) begin
					note_failure($sformatf("unexpected column result: %s", describe(res)));
				end else begin
					want = column_queue.pop_front();
					checked++;
					diffs = field_diffs(want, res);
					if (diffs != "") begin
						note_failure($sformatf("column result %0d,%s differ: expected %s, got %s",
							checked, diffs, describe(want), describe(res)));
					end
				end
			end
			if (req_valid && !req_stall) begin
				predict_request(req);
			end
		end
		pending = column_queue.size();
	end

endmodule

### verif/tb.sv
// Testbench top for the LED panel BCM scan driver: stimulus, clock, reset and verdict.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lpbcm_pkg::*;

	localparam int CLK_PERIOD = 10;
	localparam int PANEL_W = 64;
	localparam int PANEL_H = 32;
	localparam int PHASES = 6;
	localparam int DRAIN_CYCLES = 16;
	localparam int HOLD_CYCLES = 400;
	localparam int RUN_LIMIT = 2500000;

	// Width, height and blank setting of each random phase, with its number of requests.
	localparam int PH_W [PHASES] = '{127, 0, 5, 3, 2, 40};
	localparam int PH_H [PHASES] = '{64, 0, 1, 16, 2, 33};
	localparam int PH_BLANK [PHASES] = '{1, 0, 1, 0, 1, 0};
	localparam int PH_ITEMS [PHASES] = '{50, 50, 45, 50, 45, 50};

	logic clk = 1'b0;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req;
	logic res_valid;
	logic res_stall;
	res_t res;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	int pending;
	logic [7:0] dwell_now;
	int checked;
	int fail_count;

	int cycle_count = 0;
	int writes_sent = 0;
	int ticks_sent = 0;
	bit sender_calm = 1'b0;
	bit squeeze = 1'b0;

	always #(CLK_PERIOD / 2) clk = ~clk;

	led_panel_bcm_scan_driver_core #(
		.MAX_WIDTH(PANEL_W),
		.MAX_HEIGHT(PANEL_H)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	bcm_scan_checker #(
		.MAX_WIDTH(PANEL_W),
		.MAX_HEIGHT(PANEL_H)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.pending(pending),
		.dwell_now(dwell_now),
		.checked(checked),
		.fail_count(fail_count)
	);

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= RUN_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Result side: a random stall before each result, calm stretches, and one long hold-off.
	initial begin : receiver
		int n;
		bit calm;
		calm = 1'b0;
		res_stall = 1'b0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			if ($urandom_range(0, 31) == 0) begin
				calm = !calm;
			end
			n = squeeze ? HOLD_CYCLES : (calm ? 0 : $urandom_range(0, 7));
			squeeze = 1'b0;
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(negedge clk);
				res_stall <= 1'b0;
			end
			do @(posedge clk); while (!res_valid);
			@(negedge clk);
		end
	end

	task automatic offer(input req_t item);
		int gap;
		if ($urandom_range(0, 31) == 0) begin
			sender_calm = !sender_calm;
		end
		gap = sender_calm ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req <= item;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
		if (item.operation == OP_WRITE) begin
			writes_sent++;
		end else begin
			ticks_sent++;
		end
	endtask

	task automatic put_byte(input int addr, input int value);
		req_t item;
		item.operation = OP_WRITE;
		item.byte_address = BYTE_ADDR_W'(addr);
		item.byte_value = 8'(value);
		offer(item);
	endtask

	task automatic tick();
		req_t item;
		item.operation = OP_TICK;
		item.byte_address = BYTE_ADDR_W'($urandom);
		item.byte_value = 8'($urandom);
		offer(item);
	endtask

	task automatic cfg_write(input logic [CFG_INDEX_W-1:0] index, input int value);
		cfg_index <= index;
		cfg_data <= CFG_DATA_W'(value);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_sizes(input int w, input int h, input int blank);
		cfg_write(CFG_ACTIVE_WIDTH, w);
		cfg_write(CFG_ACTIVE_HEIGHT, h);
		cfg_write(CFG_DISPLAY_BLANK, blank);
		cfg_valid <= 1'b0;
	endtask

	// Waits until every predicted column has come out and the last request has settled.
	task automatic drain();
		req_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	initial begin : stimulus
		int span;
		int pick;
		int w_eff;
		int h_eff;
		int phase_end;
		int left;
		int run;
		req_valid = 1'b0;
		req = '0;
		cfg_valid = 1'b0;
		cfg_index = CFG_ACTIVE_WIDTH;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// Full panel: corner pixels, both halves, out-of-range writes, then the first planes.
		set_sizes(64, 32, 0);
		put_byte(0, 255);
		put_byte(4, 1);
		put_byte(8, 128);
		put_byte(3072, 8'h55);
		put_byte(3263, 8'hAA);
		put_byte(191, 255);
		put_byte(6143, 255);
		put_byte(6144, 255);
		put_byte(8191, 255);
		put_byte(2, 0);
		tick();
		tick();
		tick();
		tick();
		put_byte(0, 8'h0F);
		repeat (4) tick();
		drain();

		for (int p = 0; p < PHASES; p++) begin
			set_sizes(PH_W[p], PH_H[p], PH_BLANK[p]);
			w_eff = (PH_W[p] > PANEL_W) ? PANEL_W : ((PH_W[p] == 0) ? 1 : PH_W[p]);
			h_eff = (PH_H[p] > PANEL_H) ? PANEL_H : PH_H[p];
			span = w_eff * h_eff * BYTES_PER_PIXEL;
			if (p == 0) begin
				squeeze = 1'b1;
			end
			phase_end = writes_sent + ticks_sent + PH_ITEMS[p];
			while (writes_sent + ticks_sent < phase_end) begin
				left = phase_end - (writes_sent + ticks_sent);
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					pick = $urandom_range(0, 19);
					if (span > 0 && pick < 16) begin
						put_byte($urandom_range(0, span - 1), $urandom_range(0, 255));
					end else if (pick < 18) begin
						put_byte($urandom_range(0, 8191), $urandom_range(0, 255));
					end else begin
						put_byte(span, $urandom_range(0, 255));
					end
				end else if (pick < 90) begin
					// Run the dwell down so that the next plane is shifted out.
					run = (int'(dwell_now) > left) ? left : int'(dwell_now);
					repeat (run) tick();
				end else begin
					run = $urandom_range(1, 3);
					if (run > left) begin
						run = left;
					end
					repeat (run) tick();
				end
			end
			drain();
		end

		$display("Covered %0d panel settings with %0d byte writes and %0d time ticks.",
			PHASES + 1, writes_sent, ticks_sent);
		$display("%0d column results were compared.", checked);
		if (fail_count == 0 && pending == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/lpbcm_pkg.sv
hw/rtl/lpbcm_ram.sv
hw/rtl/led_panel_bcm_scan_driver_core.sv
verif/bcm_scan_checker.sv
verif/tb.sv
